>>> rtl/rkct_pkg.sv
package rkct_pkg;

  localparam int DEF_ENTRIES  = 64;
  localparam int DEF_REF_BITS = 8;

  localparam int OPC_W  = 2;
  localparam int PART_W = 2;
  localparam int OBJ_W  = 16;
  localparam int SLOT_W = 6;
  localparam int REFO_W = 8;
  localparam int STAT_W = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_GET  = 2'd0,
    OP_DUP  = 2'd1,
    OP_PUT  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_FREE  = 2'd2,
    ST_SATUR = 2'd3
  } status_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic [REFO_W-1:0] refs;
    status_t           status;
  } res_t;

endpackage

>>> rtl/refcounted_key_cache_table_unit.sv
// Reference-counted key cache table. Each transfer on the input channel is
// one get, dup, put or no-op and yields exactly one result transfer. The
// table sits in a single-port-write, registered-read memory and one
// compare/increment unit walks it: a get reads every slot once, one per
// cycle, and stops early when a live match is found; dup and put read one
// slot, or none when the slot number is out of range.
// in_stall stays high while an operation is in flight. After reset the block
// clears the table one slot per cycle and takes no input until every slot is
// cleared. A finished result waits in the output register, and the next
// operation starts while it waits.
module refcounted_key_cache_table_unit
  import rkct_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int REF_BITS = DEF_REF_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [PART_W-1:0] in_part_id,
  input  logic [OBJ_W-1:0]  in_object_num,
  input  logic [SLOT_W-1:0] in_slot_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] out_slot_out,
  output logic              out_hit,
  output logic [REFO_W-1:0] out_ref_after,
  output logic [STAT_W-1:0] out_status
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_r;
  res_t out_r;

  rkct_ctrl #(
    .ENTRIES  (ENTRIES),
    .REF_BITS (REF_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_part_id    (in_part_id),
    .in_object_num (in_object_num),
    .in_slot_in    (in_slot_in),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slot_out  = out_r.slot;
  assign out_hit       = out_r.hit;
  assign out_ref_after = out_r.refs;
  assign out_status    = out_r.status;

endmodule

>>> rtl/rkct_mem.sv
module rkct_mem
  import rkct_pkg::*;
#(
  parameter int DEPTH = DEF_ENTRIES,
  parameter int WIDTH = PART_W + OBJ_W + DEF_REF_BITS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/rkct_unit.sv
module rkct_unit
  import rkct_pkg::*;
#(
  parameter int REF_BITS = DEF_REF_BITS
) (
  input  logic [PART_W-1:0]   ent_part,
  input  logic [OBJ_W-1:0]    ent_obj,
  input  logic [REF_BITS-1:0] ent_refs,
  input  logic [PART_W-1:0]   key_part,
  input  logic [OBJ_W-1:0]    key_obj,
  output logic                live_match,
  output logic                is_free,
  output logic                is_sat,
  output logic [REF_BITS-1:0] refs_inc,
  output logic [REF_BITS-1:0] refs_dec
);

  assign is_free    = (ent_refs == '0);
  assign is_sat     = &ent_refs;
  assign live_match = !is_free && (ent_part == key_part) && (ent_obj == key_obj);
  assign refs_inc   = ent_refs + REF_BITS'(1);
  assign refs_dec   = ent_refs - REF_BITS'(1);

endmodule

>>> rtl/rkct_ctrl.sv
module rkct_ctrl
  import rkct_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int REF_BITS = DEF_REF_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [PART_W-1:0] in_part_id,
  input  logic [OBJ_W-1:0]  in_object_num,
  input  logic [SLOT_W-1:0] in_slot_in,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW = PART_W + OBJ_W + REF_BITS;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ONE,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [PART_W-1:0]   part_r, part_nxt;
  logic [OBJ_W-1:0]    obj_r, obj_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                have_free_r, have_free_nxt;
  logic [IW-1:0]       free_idx_r, free_idx_nxt;
  res_t                res_r, res_nxt;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [DW-1:0]       wr_data;
  logic [IW-1:0]       rd_addr;
  logic [DW-1:0]       rd_data;

  logic [PART_W-1:0]   ent_part;
  logic [OBJ_W-1:0]    ent_obj;
  logic [REF_BITS-1:0] ent_refs;
  logic                live_match, is_free, is_sat;
  logic [REF_BITS-1:0] refs_inc, refs_dec;
  logic                accept;
  logic                slot_oob;

  assign {ent_part, ent_obj, ent_refs} = rd_data;

  rkct_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (DW),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rkct_unit #(
    .REF_BITS (REF_BITS)
  ) u_unit (
    .ent_part   (ent_part),
    .ent_obj    (ent_obj),
    .ent_refs   (ent_refs),
    .key_part   (part_r),
    .key_obj    (obj_r),
    .live_match (live_match),
    .is_free    (is_free),
    .is_sat     (is_sat),
    .refs_inc   (refs_inc),
    .refs_dec   (refs_dec)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_oob  = (32'(in_slot_in) >= ENTRIES);
  assign res_valid = (state_r == S_FIN);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    part_nxt      = part_r;
    obj_nxt       = obj_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '0;
    rd_addr       = idx_r + IW'(1);

    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = (op_t'(in_opcode) == OP_GET) ? '0 : IW'(in_slot_in);
        if (accept) begin
          op_nxt   = op_t'(in_opcode);
          part_nxt = in_part_id;
          obj_nxt  = in_object_num;
          slot_nxt = IW'(in_slot_in);
          case (op_t'(in_opcode))
            OP_GET: begin
              idx_nxt       = '0;
              have_free_nxt = 1'b0;
              state_nxt     = S_SCAN;
            end
            OP_DUP, OP_PUT: begin
              if (slot_oob) begin
                res_nxt   = '{slot: in_slot_in, hit: 1'b0, refs: '0, status: ST_FREE};
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_ONE;
              end
            end
            default: begin
              res_nxt   = '{slot: '0, hit: 1'b0, refs: '0, status: ST_OK};
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + IW'(1);
        if (is_free && !have_free_r) begin
          have_free_nxt = 1'b1;
          free_idx_nxt  = idx_r;
        end
        if (live_match) begin
          state_nxt = S_FIN;
          if (is_sat) begin
            res_nxt = '{slot: SLOT_W'(idx_r), hit: 1'b1, refs: REFO_W'(ent_refs),
                        status: ST_SATUR};
          end else begin
            wr_en   = 1'b1;
            wr_addr = idx_r;
            wr_data = {ent_part, ent_obj, refs_inc};
            res_nxt = '{slot: SLOT_W'(idx_r), hit: 1'b1, refs: REFO_W'(refs_inc),
                        status: ST_OK};
          end
        end else if (idx_r == LAST) begin
          state_nxt = S_FIN;
          if (have_free_r || is_free) begin
            wr_en   = 1'b1;
            wr_addr = have_free_r ? free_idx_r : idx_r;
            wr_data = {part_r, obj_r, REF_BITS'(1)};
            res_nxt = '{slot: SLOT_W'(wr_addr), hit: 1'b0, refs: REFO_W'(1),
                        status: ST_OK};
          end else begin
            res_nxt = '{slot: '0, hit: 1'b0, refs: '0, status: ST_FULL};
          end
        end
      end
      S_ONE: begin
        state_nxt = S_FIN;
        wr_addr   = slot_r;
        if (op_r == OP_DUP) begin
          if (is_sat) begin
            res_nxt = '{slot: SLOT_W'(slot_r), hit: 1'b0, refs: REFO_W'(ent_refs),
                        status: ST_SATUR};
          end else begin
            wr_en   = 1'b1;
            wr_data = {ent_part, ent_obj, refs_inc};
            res_nxt = '{slot: SLOT_W'(slot_r), hit: 1'b0, refs: REFO_W'(refs_inc),
                        status: ST_OK};
          end
        end else begin
          if (is_free) begin
            res_nxt = '{slot: SLOT_W'(slot_r), hit: 1'b0, refs: '0, status: ST_FREE};
          end else begin
            wr_en   = 1'b1;
            wr_data = {ent_part, ent_obj, refs_dec};
            res_nxt = '{slot: SLOT_W'(slot_r), hit: 1'b0, refs: REFO_W'(refs_dec),
                        status: ST_OK};
          end
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      have_free_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      have_free_r <= have_free_nxt;
    end
    op_r       <= op_nxt;
    part_r     <= part_nxt;
    obj_r      <= obj_nxt;
    slot_r     <= slot_nxt;
    free_idx_r <= free_idx_nxt;
    res_r      <= res_nxt;
  end

endmodule
